// ===== design/gasp_pkg.sv =====
// Shared types, constants and helper functions for the grid path search block.
// No dependencies; imported by grid_astar_path_search.
`default_nettype none
package gasp_pkg;

  localparam int CELL_W = 6;
  localparam int COST_W = 11;
  localparam int SEQ_W = 6;
  localparam logic [COST_W-1:0] COST_INF = 11'h7FF;
  localparam logic [3:0] STRAIGHT = 4'd10;
  localparam logic [3:0] DIAGONAL = 4'd14;
  localparam logic [3:0] ROOT_MARK = 4'd8;

  localparam logic [1:0] STAT_GOAL = 2'd0;
  localparam logic [1:0] STAT_PARTIAL = 2'd1;
  localparam logic [1:0] STAT_NONE = 2'd2;

  localparam logic OP_WALL = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POP_CHK,
    ST_SCAN,
    ST_POP_FIX,
    ST_POP_CMP,
    ST_EXPAND,
    ST_TRACE_START,
    ST_TRACE_RD,
    ST_TRACE_WR,
    ST_NOPATH,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    logic [COST_W-1:0] f;
    logic [COST_W-1:0] g;
    logic [SEQ_W-1:0] seq;
    logic [CELL_W-1:0] loc;
  } heap_entry_t;

  function automatic logic [3:0] step_dx(input logic [2:0] d);
    logic [3:0] r;
    unique case (d)
      3'd0, 3'd2: r = 4'd0;
      3'd1, 3'd4, 3'd5: r = 4'hF;
      default: r = 4'd1;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] step_dy(input logic [2:0] d);
    logic [3:0] r;
    unique case (d)
      3'd1, 3'd3: r = 4'd0;
      3'd0, 3'd4, 3'd7: r = 4'hF;
      default: r = 4'd1;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] step_cost(input logic [2:0] d);
    return d[2] ? DIAGONAL : STRAIGHT;
  endfunction

  function automatic logic [6:0] heur(input logic [2:0] x, input logic [2:0] y,
                                      input logic [2:0] gx, input logic [2:0] gy);
    logic [2:0] dx;
    logic [2:0] dy;
    logic [2:0] m;
    dx = (gx > x) ? gx - x : x - gx;
    dy = (gy > y) ? gy - y : y - gy;
    m = (dx > dy) ? dx : dy;
    return 7'(m) * 7'(DIAGONAL);
  endfunction

  function automatic logic entry_before(input heap_entry_t a, input heap_entry_t b);
    logic r;
    if (a.f != b.f) begin
      r = a.f < b.f;
    end else if (a.g != b.g) begin
      r = a.g < b.g;
    end else begin
      r = a.seq < b.seq;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/grid_astar_path_search.sv =====
// Top level of the grid A* path search: map store, open list, search sequencer and path output.
// Depends on gasp_pkg for types, step tables and the heuristic.
//
// Usage: an input transfer with opcode 0 writes one row of the obstacle map and produces
// nothing. A transfer with opcode 1 runs an 8-connected search from start to goal and then
// produces the path, start first, one cell per output transfer, with last set on the final one.
// When nothing is discovered a single item with status 2 is produced.
// Each pop makes a linear scan of the open-list entries in the heap memory; each expanded
// cell then visits its eight neighbours in turn, and the path is traced back from its end
// and output start first. in_stall is high while a search runs and its path is produced.
// The output register holds an item until the receiver lowers out_stall; the next input
// is taken while the final item still waits. The grid size register is written through
// cfg_we and cfg_wdata; the user must write it only while the block is idle, since the
// block itself does not enforce this. Reset clears the map, the grid size returns to 8 and
// no output is pending; no clearing pass is needed.
`default_nettype none
module grid_astar_path_search
  import gasp_pkg::*;
#(
  parameter int GRID_SIDE = 8,
  parameter int HEAP_DEPTH = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_opcode,
  input  wire logic [2:0] in_row_index,
  input  wire logic [7:0] in_wall_mask,
  input  wire logic [2:0] in_start_x,
  input  wire logic [2:0] in_start_y,
  input  wire logic [2:0] in_goal_x,
  input  wire logic [2:0] in_goal_y,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_path_x,
  output logic [2:0]      out_path_y,
  output logic [1:0]      out_status,
  output logic            out_last
);

  localparam int HCW = $clog2(HEAP_DEPTH + 1);
  localparam int HAW = $clog2(HEAP_DEPTH);
  localparam logic [HCW-1:0] HEAP_FULL = HCW'(HEAP_DEPTH);
  localparam logic [3:0] SIDE_LIM = 4'(GRID_SIDE);

  state_t state_r, state_nxt;
  logic [3:0] grid_size_r, grid_size_nxt;
  logic [7:0] wall_r [8];
  logic [63:0] closed_r, closed_nxt;
  logic [HCW-1:0] count_r, count_nxt;
  logic [6:0] seq_r, seq_nxt;
  logic found_r, found_nxt;
  logic last_valid_r, last_valid_nxt;
  logic [CELL_W-1:0] last_cell_r, last_cell_nxt;
  heap_entry_t best_r, best_nxt;
  logic [HAW-1:0] best_idx_r, best_idx_nxt;
  heap_entry_t last_ent_r, last_ent_nxt;
  logic [HCW-1:0] scan_i_r, scan_i_nxt;
  logic pend_r, pend_nxt;
  logic [HCW-1:0] pend_idx_r, pend_idx_nxt;
  logic [2:0] dir_r, dir_nxt;
  logic [2:0] gx_r, gx_nxt, gy_r, gy_nxt;
  logic [CELL_W-1:0] pos_r, pos_nxt;
  logic [6:0] trace_n_r, trace_n_nxt;
  logic [6:0] emit_k_r, emit_k_nxt;
  logic [1:0] status_r, status_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [2:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  logic out_last_r, out_last_nxt;

  heap_entry_t heap_mem [HEAP_DEPTH];
  heap_entry_t heap_rd_r;
  logic heap_we;
  logic [HAW-1:0] heap_wa;
  heap_entry_t heap_wd;

  logic [COST_W-1:0] bc_mem [64];
  logic [COST_W-1:0] bc_rd_r;
  logic bc_we;
  logic [CELL_W-1:0] bc_wa;
  logic [COST_W-1:0] bc_wd;

  logic [3:0] pd_mem [64];
  logic [3:0] pd_rd_r;
  logic pd_we;
  logic [CELL_W-1:0] pd_wa;
  logic [3:0] pd_wd;

  logic [CELL_W-1:0] pb_mem [64];
  logic [CELL_W-1:0] pb_rd_r;
  logic pb_we;
  logic [6:0] emit_addr;

  logic wall_we;
  logic out_free;
  logic [3:0] size_lim;
  logic [3:0] nx4, ny4;
  logic in_map, is_goal, passable;
  logic [CELL_W-1:0] ncell;
  logic [12:0] g_new, f_new;
  logic [CELL_W-1:0] start_cell;
  logic [6:0] start_h;
  logic [3:0] back_dx, back_dy;
  logic [2:0] back_x, back_y;

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_path_x = out_x_r;
  assign out_path_y = out_y_r;
  assign out_status = out_status_r;
  assign out_last = out_last_r;

  assign out_free = !out_valid_r || !out_stall;
  assign size_lim = (grid_size_r > SIDE_LIM) ? SIDE_LIM : grid_size_r;
  assign nx4 = {1'b0, best_r.loc[2:0]} + step_dx(dir_r);
  assign ny4 = {1'b0, best_r.loc[5:3]} + step_dy(dir_r);
  assign in_map = !nx4[3] && !ny4[3];
  assign is_goal = in_map && (nx4[2:0] == gx_r) && (ny4[2:0] == gy_r);
  assign passable = in_map && (nx4 < size_lim) && (ny4 < size_lim) &&
                    !wall_r[ny4[2:0]][nx4[2:0]];
  assign ncell = {ny4[2:0], nx4[2:0]};
  assign g_new = 13'(best_r.g) + 13'(step_cost(dir_r));
  assign f_new = g_new + 13'(heur(nx4[2:0], ny4[2:0], gx_r, gy_r));
  assign start_cell = {in_start_y, in_start_x};
  assign start_h = heur(in_start_x, in_start_y, in_goal_x, in_goal_y);
  assign back_dx = step_dx(pd_rd_r[2:0]);
  assign back_dy = step_dy(pd_rd_r[2:0]);
  assign back_x = pos_r[2:0] - back_dx[2:0];
  assign back_y = pos_r[5:3] - back_dy[2:0];
  assign emit_addr = trace_n_r - 7'd1 - emit_k_r;

  always_comb begin
    state_nxt = state_r;
    grid_size_nxt = cfg_we ? cfg_wdata : grid_size_r;
    closed_nxt = closed_r;
    count_nxt = count_r;
    seq_nxt = seq_r;
    found_nxt = found_r;
    last_valid_nxt = last_valid_r;
    last_cell_nxt = last_cell_r;
    best_nxt = best_r;
    best_idx_nxt = best_idx_r;
    last_ent_nxt = last_ent_r;
    scan_i_nxt = scan_i_r;
    pend_nxt = pend_r;
    pend_idx_nxt = pend_idx_r;
    dir_nxt = dir_r;
    gx_nxt = gx_r;
    gy_nxt = gy_r;
    pos_nxt = pos_r;
    trace_n_nxt = trace_n_r;
    emit_k_nxt = emit_k_r;
    status_nxt = status_r;
    out_valid_nxt = (out_valid_r && !out_stall) ? 1'b0 : out_valid_r;
    out_x_nxt = out_x_r;
    out_y_nxt = out_y_r;
    out_status_nxt = out_status_r;
    out_last_nxt = out_last_r;
    wall_we = 1'b0;
    heap_we = 1'b0;
    heap_wa = count_r[HAW-1:0];
    heap_wd = best_r;
    bc_we = 1'b0;
    bc_wa = ncell;
    bc_wd = f_new[COST_W-1:0];
    pd_we = 1'b0;
    pd_wa = ncell;
    pd_wd = {1'b0, dir_r};
    pb_we = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_WALL) begin
            wall_we = 1'b1;
          end else begin
            gx_nxt = in_goal_x;
            gy_nxt = in_goal_y;
            closed_nxt = '0;
            closed_nxt[start_cell] = 1'b1;
            bc_we = 1'b1;
            bc_wa = start_cell;
            bc_wd = COST_W'(start_h);
            pd_we = 1'b1;
            pd_wa = start_cell;
            pd_wd = ROOT_MARK;
            heap_we = 1'b1;
            heap_wa = '0;
            heap_wd = '{f: COST_W'(start_h), g: '0, seq: '0, loc: start_cell};
            count_nxt = HCW'(1);
            seq_nxt = 7'd1;
            found_nxt = 1'b0;
            last_valid_nxt = 1'b0;
            state_nxt = ST_POP_CHK;
          end
        end
      end
      ST_POP_CHK: begin
        if (found_r || count_r == '0) begin
          state_nxt = ST_TRACE_START;
        end else begin
          scan_i_nxt = '0;
          pend_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_i_r < count_r) begin
          pend_nxt = 1'b1;
          pend_idx_nxt = scan_i_r;
          scan_i_nxt = scan_i_r + HCW'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = ST_POP_FIX;
          end
        end
        if (pend_r) begin
          if (pend_idx_r == '0 || entry_before(heap_rd_r, best_r)) begin
            best_nxt = heap_rd_r;
            best_idx_nxt = pend_idx_r[HAW-1:0];
          end
          if (pend_idx_r == count_r - HCW'(1)) begin
            last_ent_nxt = heap_rd_r;
          end
        end
      end
      ST_POP_FIX: begin
        count_nxt = count_r - HCW'(1);
        heap_we = 1'b1;
        heap_wa = best_idx_r;
        heap_wd = last_ent_r;
        state_nxt = ST_POP_CMP;
      end
      ST_POP_CMP: begin
        dir_nxt = '0;
        state_nxt = (bc_rd_r < best_r.f) ? ST_POP_CHK : ST_EXPAND;
      end
      ST_EXPAND: begin
        dir_nxt = dir_r + 3'd1;
        if (dir_r == 3'd7) begin
          state_nxt = ST_POP_CHK;
        end
        if (is_goal) begin
          pd_we = 1'b1;
          found_nxt = 1'b1;
          state_nxt = ST_POP_CHK;
        end else if (passable && !closed_r[ncell]) begin
          last_valid_nxt = 1'b1;
          last_cell_nxt = ncell;
          if (f_new < 13'(COST_INF)) begin
            closed_nxt[ncell] = 1'b1;
            bc_we = 1'b1;
            pd_we = 1'b1;
            seq_nxt = seq_r + 7'd1;
            if (count_r < HEAP_FULL) begin
              heap_we = 1'b1;
              heap_wd = '{f: f_new[COST_W-1:0], g: g_new[COST_W-1:0],
                          seq: seq_r[SEQ_W-1:0], loc: ncell};
              count_nxt = count_r + HCW'(1);
            end
          end
        end
      end
      ST_TRACE_START: begin
        trace_n_nxt = '0;
        if (found_r) begin
          pos_nxt = {gy_r, gx_r};
          status_nxt = STAT_GOAL;
          state_nxt = ST_TRACE_RD;
        end else if (last_valid_r) begin
          pos_nxt = last_cell_r;
          status_nxt = STAT_PARTIAL;
          state_nxt = ST_TRACE_RD;
        end else begin
          state_nxt = ST_NOPATH;
        end
      end
      ST_TRACE_RD: begin
        state_nxt = ST_TRACE_WR;
      end
      ST_TRACE_WR: begin
        pb_we = 1'b1;
        trace_n_nxt = trace_n_r + 7'd1;
        if (pd_rd_r[3] || trace_n_r == 7'd63) begin
          emit_k_nxt = '0;
          state_nxt = ST_EMIT_RD;
        end else begin
          pos_nxt = {back_y, back_x};
          state_nxt = ST_TRACE_RD;
        end
      end
      ST_NOPATH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt = '0;
          out_y_nxt = '0;
          out_status_nxt = STAT_NONE;
          out_last_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        if (out_free) begin
          state_nxt = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        out_valid_nxt = 1'b1;
        out_x_nxt = pb_rd_r[2:0];
        out_y_nxt = pb_rd_r[5:3];
        out_status_nxt = status_r;
        out_last_nxt = (emit_addr == '0);
        emit_k_nxt = emit_k_r + 7'd1;
        state_nxt = (emit_addr == '0) ? ST_IDLE : ST_EMIT_RD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= 4'd8;
      closed_r <= '0;
      count_r <= '0;
      seq_r <= '0;
      found_r <= 1'b0;
      last_valid_r <= 1'b0;
      pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        wall_r[i] <= '0;
      end
    end else begin
      grid_size_r <= grid_size_nxt;
      closed_r <= closed_nxt;
      count_r <= count_nxt;
      seq_r <= seq_nxt;
      found_r <= found_nxt;
      last_valid_r <= last_valid_nxt;
      pend_r <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (wall_we) begin
        wall_r[in_row_index] <= in_wall_mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    last_cell_r <= last_cell_nxt;
    best_r <= best_nxt;
    best_idx_r <= best_idx_nxt;
    last_ent_r <= last_ent_nxt;
    scan_i_r <= scan_i_nxt;
    pend_idx_r <= pend_idx_nxt;
    dir_r <= dir_nxt;
    gx_r <= gx_nxt;
    gy_r <= gy_nxt;
    pos_r <= pos_nxt;
    trace_n_r <= trace_n_nxt;
    emit_k_r <= emit_k_nxt;
    status_r <= status_nxt;
    out_x_r <= out_x_nxt;
    out_y_r <= out_y_nxt;
    out_status_r <= out_status_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_wa] <= heap_wd;
    end
    heap_rd_r <= heap_mem[scan_i_r[HAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (bc_we) begin
      bc_mem[bc_wa] <= bc_wd;
    end
    bc_rd_r <= bc_mem[best_r.loc];
  end

  always_ff @(posedge clk) begin
    if (pd_we) begin
      pd_mem[pd_wa] <= pd_wd;
    end
    pd_rd_r <= pd_mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (pb_we) begin
      pb_mem[trace_n_r[5:0]] <= pos_r;
    end
    pb_rd_r <= pb_mem[emit_addr[5:0]];
  end

endmodule
`default_nettype wire
